>>> hdl/bmu_pkg.sv
`timescale 1ns / 1ps

package bmu_pkg;

    // Port field widths
    localparam int DATA_W = 64;
    localparam int FUNC_W = 4;
    localparam int WSEL_W = 2;
    localparam int ROT_W  = 6;

    // Widest operand supported by default
    localparam int MAX_WIDTH_DEF = 64;

    // Narrowest operand width; width codes scale it by powers of two
    localparam int MIN_W = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ROTL   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ROTR   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_CLZ    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_CLO    = 4'd3;
    localparam logic [FUNC_W-1:0] FN_CTZ    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_CTO    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_POPCNT = 4'd6;
    localparam logic [FUNC_W-1:0] FN_ISPOW2 = 4'd7;
    localparam logic [FUNC_W-1:0] FN_FLOOR2 = 4'd8;
    localparam logic [FUNC_W-1:0] FN_CEIL2  = 4'd9;
    localparam logic [FUNC_W-1:0] FN_BITW   = 4'd10;
    localparam logic [FUNC_W-1:0] FN_LAST   = FN_BITW;

endpackage

>>> hdl/bit_manipulation_unit_top.sv
// Bit manipulation unit: rotates, leading/trailing zero and one counts,
// population count, power-of-two test, floor/ceiling to a power of two and
// bit width, on an 8, 16, 32 or 64 bit operand (capped at MAX_WIDTH). The
// unit accepts one beat per clock while the output side does not stall and
// returns one result beat per input beat, in order. A beat passes through
// four register stages: decode and mask, shift and align, count, and result
// select. Each stage holds its beat under back-pressure, so empty stages
// still take new beats while the output waits. Unused operation codes
// return zero.
`timescale 1ns / 1ps

module bit_manipulation_unit_top #(
    parameter int MAX_WIDTH = bmu_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input beat
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bmu_pkg::FUNC_W-1:0]  i_func,
    input  logic [bmu_pkg::WSEL_W-1:0]  i_width_sel,
    input  logic [bmu_pkg::DATA_W-1:0]  i_operand,
    input  logic [bmu_pkg::ROT_W-1:0]   i_rot_count,
    // result beat
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bmu_pkg::DATA_W-1:0]  o_result
);
    import bmu_pkg::*;

    localparam int DW   = MAX_WIDTH;
    localparam int CW   = $clog2(DW + 1);
    localparam int RW   = $clog2(DW);
    localparam int NCH  = (DW + 7) / 8;
    localparam int PADW = NCH * 8;
    localparam logic [DW-1:0] ONE = DW'(1);

    // Stage handshake: a stage moves when it is empty or its successor moves
    logic rdy1, rdy2, rdy3, rdy4;

    // Rotate count modulo the capped width, one entry per count value
    logic [RW-1:0] rot_mod_cap [2**ROT_W];

    // Stage 1: width decode, masking, rotate count modulo
    logic              r_s1_vld;
    logic [FUNC_W-1:0] r_s1_func;
    logic [CW-1:0]     r_s1_w;
    logic [DW-1:0]     r_s1_mask, r_s1_x, r_s1_nx, r_s1_xm1;
    logic [RW-1:0]     r_s1_r;
    logic              r_s1_le1;

    logic [CW-1:0] n_s1_w;
    logic [DW-1:0] n_s1_mask, n_s1_x, n_s1_nx, n_s1_xm1;
    logic [RW-1:0] n_s1_r;
    logic          n_s1_le1;

    // Stage 2: rotate, scan vector alignment, per-byte popcount
    logic              r_s2_vld;
    logic [FUNC_W-1:0] r_s2_func;
    logic [CW-1:0]     r_s2_w;
    logic [DW-1:0]     r_s2_rot, r_s2_scan;
    logic [3:0]        r_s2_pc [NCH];
    logic              r_s2_le1;

    logic [DW-1:0] n_s2_rot, n_s2_scan;
    logic [3:0]    n_s2_pc [NCH];

    // Stage 3: trailing zero count of the scan vector, popcount sum
    logic              r_s3_vld;
    logic [FUNC_W-1:0] r_s3_func;
    logic [CW-1:0]     r_s3_w;
    logic [DW-1:0]     r_s3_rot;
    logic [CW-1:0]     r_s3_cnt, r_s3_pop;
    logic              r_s3_le1;

    logic [CW-1:0] n_s3_cnt, n_s3_pop;

    // Stage 4: output register
    logic          r_s4_vld;
    logic [DW-1:0] r_s4_res;
    logic [DW-1:0] n_s4_res;

    assign rdy4    = !r_s4_vld || i_ready;
    assign rdy3    = !r_s3_vld || rdy4;
    assign rdy2    = !r_s2_vld || rdy3;
    assign rdy1    = !r_s1_vld || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_s4_vld;
    assign o_result = DATA_W'(r_s4_res);

    // constant table for a cap that need not be a power of two
    for (genvar g = 0; g < 2**ROT_W; g++) begin : g_rot_mod
        assign rot_mod_cap[g] = RW'(g % DW);
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        logic [7:0] wsel8;
        logic [7:0] wmax8;
        wsel8 = 8'(MIN_W) << i_width_sel;
        wmax8 = 8'(DW);
        n_s1_w = (wsel8 > wmax8) ? CW'(wmax8) : CW'(wsel8);
        n_s1_mask = ~({DW{1'b1}} << n_s1_w);
        n_s1_x    = i_operand[DW-1:0] & n_s1_mask;
        n_s1_nx   = ~n_s1_x & n_s1_mask;
        n_s1_xm1  = (n_s1_x - ONE) & n_s1_mask;
        n_s1_le1  = (n_s1_x <= ONE);
        // rotate count modulo width: low bits below the cap, table at the cap
        n_s1_r = (n_s1_w == CW'(DW)) ? rot_mod_cap[i_rot_count]
                                     : (i_rot_count[RW-1:0] & RW'(n_s1_w - CW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy1) begin
            r_s1_vld <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_s1_func <= i_func;
            r_s1_w    <= n_s1_w;
            r_s1_mask <= n_s1_mask;
            r_s1_x    <= n_s1_x;
            r_s1_nx   <= n_s1_nx;
            r_s1_xm1  <= n_s1_xm1;
            r_s1_r    <= n_s1_r;
            r_s1_le1  <= n_s1_le1;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        logic [CW-1:0]   back;
        logic [CW-1:0]   lshift;
        logic [DW-1:0]   lead_v;
        logic [DW-1:0]   lead_al;
        logic [DW-1:0]   lead_rev;
        logic [PADW-1:0] xpad;
        back = r_s1_w - CW'(r_s1_r);
        if (r_s1_func == FN_ROTR) begin
            n_s2_rot = ((r_s1_x >> r_s1_r) | (r_s1_x << back)) & r_s1_mask;
        end else begin
            n_s2_rot = ((r_s1_x << r_s1_r) | (r_s1_x >> back)) & r_s1_mask;
        end
        // leading counts: left-align within DW, then bit-reverse
        case (r_s1_func)
            FN_CLO:   lead_v = r_s1_nx;
            FN_CEIL2: lead_v = r_s1_xm1;
            default:  lead_v = r_s1_x;
        endcase
        lshift  = CW'(DW) - r_s1_w;
        lead_al = lead_v << lshift;
        for (int i = 0; i < DW; i++) begin
            lead_rev[i] = lead_al[DW-1-i];
        end
        case (r_s1_func)
            FN_CTZ:  n_s2_scan = r_s1_x;
            FN_CTO:  n_s2_scan = r_s1_nx;
            default: n_s2_scan = lead_rev;
        endcase
        // popcount per byte
        xpad = PADW'(r_s1_x);
        for (int c = 0; c < NCH; c++) begin
            n_s2_pc[c] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                n_s2_pc[c] = n_s2_pc[c] + 4'(xpad[c*8+b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (rdy2) begin
            r_s2_vld <= r_s1_vld;
        end
        if (rdy2 && r_s1_vld) begin
            r_s2_func <= r_s1_func;
            r_s2_w    <= r_s1_w;
            r_s2_rot  <= n_s2_rot;
            r_s2_scan <= n_s2_scan;
            r_s2_pc   <= n_s2_pc;
            r_s2_le1  <= r_s1_le1;
        end
    end

    // ---------------- stage 3 ----------------
    always_comb begin
        logic [DW-1:0] iso;
        logic [RW-1:0] enc;
        logic [CW-1:0] raw;
        // isolate lowest set bit, encode its position
        iso = r_s2_scan & (~r_s2_scan + ONE);
        enc = '0;
        for (int i = 0; i < DW; i++) begin
            if (iso[i]) begin
                enc = enc | RW'(i);
            end
        end
        raw = (r_s2_scan == '0) ? CW'(DW) : CW'(enc);
        n_s3_cnt = (raw > r_s2_w) ? r_s2_w : raw;
        n_s3_pop = '0;
        for (int c = 0; c < NCH; c++) begin
            n_s3_pop = n_s3_pop + CW'(r_s2_pc[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (rdy3) begin
            r_s3_vld <= r_s2_vld;
        end
        if (rdy3 && r_s2_vld) begin
            r_s3_func <= r_s2_func;
            r_s3_w    <= r_s2_w;
            r_s3_rot  <= r_s2_rot;
            r_s3_cnt  <= n_s3_cnt;
            r_s3_pop  <= n_s3_pop;
            r_s3_le1  <= r_s2_le1;
        end
    end

    // ---------------- stage 4: result select ----------------
    always_comb begin
        logic [CW-1:0] sig;
        sig = r_s3_w - r_s3_cnt;
        case (r_s3_func)
            FN_ROTL, FN_ROTR: n_s4_res = r_s3_rot;
            FN_CLZ, FN_CLO, FN_CTZ, FN_CTO: n_s4_res = DW'(r_s3_cnt);
            FN_POPCNT: n_s4_res = DW'(r_s3_pop);
            FN_ISPOW2: n_s4_res = (r_s3_pop == CW'(1)) ? ONE : '0;
            FN_FLOOR2: n_s4_res = (sig == '0) ? '0 : (ONE << (sig - CW'(1)));
            FN_CEIL2: begin
                if (r_s3_le1) begin
                    n_s4_res = ONE;
                end else if (sig >= r_s3_w) begin
                    n_s4_res = '0;
                end else begin
                    n_s4_res = ONE << sig;
                end
            end
            FN_BITW: n_s4_res = DW'(sig);
            default: n_s4_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (rdy4) begin
            r_s4_vld <= r_s3_vld;
        end
        if (rdy4 && r_s3_vld) begin
            r_s4_res <= n_s4_res;
        end
    end

endmodule

>>> hdl/bmu_checker.sv
`timescale 1ns / 1ps

module bmu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [bmu_pkg::FUNC_W-1:0]  i_func,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [bmu_pkg::DATA_W-1:0]  o_result
);
    import bmu_pkg::*;

    // Result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("result beat dropped or changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // Input is only refused when the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output back-pressure");

    // With the output side open, an accepted beat comes out once it has passed through the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready) ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid)
        else $error("result beat missing after pipeline latency");

    // Unused operation codes pass through a free pipeline as zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready && !o_valid && (i_func > FN_LAST))
        ##1 (i_ready && !o_valid) ##1 (i_ready && !o_valid)
        ##1 (i_ready && !o_valid)
        |=> (o_valid && (o_result == '0)))
        else $error("unused operation code gave a nonzero result");

endmodule

bind bit_manipulation_unit_top bmu_checker u_bmu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_func   (i_func),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bmu_pkg::*;

    localparam int BMU_MAX_W       = MAX_WIDTH_DEF;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PIPE_SETTLE     = 8;
    localparam int RANDOM_ITEMS    = 2000;
    localparam longint TIMEOUT_NS  = 2_000_000;

    // operand width codes
    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_32 = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_64 = 2'd3;

    // codes past the last operation must return zero
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FN_LAST + FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = '1;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum int unsigned {
        RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY
    } t_rx_mode;

    typedef enum int unsigned {
        OPND_FULL, OPND_ONE_HOT, OPND_LOW_MASK, OPND_POW2_PLUS1,
        OPND_LEAD_ZEROS, OPND_TRAIL_ZEROS, OPND_LEAD_ONES, OPND_EDGE, OPND_TINY
    } t_opnd_shape;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [WSEL_W-1:0] wsel;
        logic [DATA_W-1:0] opnd;
        logic [ROT_W-1:0]  rot;
        logic [DATA_W-1:0] result;
    } t_bmu_beat;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [WSEL_W-1:0] i_width_sel = '0;
    logic [DATA_W-1:0] i_operand   = '0;
    logic [ROT_W-1:0]  i_rot_count = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [DATA_W-1:0] o_result;

    t_bmu_beat   pending_results[$];
    int unsigned error_count      = 0;
    int unsigned burst_left       = 0;
    bit          steady_send      = 1'b0;
    bit          hold_off_pending = 1'b0;

    bit_manipulation_unit_top #(
        .MAX_WIDTH(BMU_MAX_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_width_sel (i_width_sel),
        .i_operand   (i_operand),
        .i_rot_count (i_rot_count),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned lead_zero_count(logic [DATA_W-1:0] v, int unsigned w);
        int unsigned n;
        int          i;
        n = 0;
        for (i = int'(w) - 1; i >= 0; i--) begin
            if (v[i]) break;
            n++;
        end
        return n;
    endfunction

    function automatic int unsigned trail_zero_count(logic [DATA_W-1:0] v, int unsigned w);
        int unsigned n;
        int          i;
        n = 0;
        for (i = 0; i < int'(w); i++) begin
            if (v[i]) break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] bmu_expected(
        logic [FUNC_W-1:0] fn, logic [WSEL_W-1:0] wsel,
        logic [DATA_W-1:0] opnd, logic [ROT_W-1:0] rot
    );
        int unsigned       w;
        int unsigned       r;
        int unsigned       nbits;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] nx;
        logic [DATA_W-1:0] res;
        w = 8 << wsel;
        if (w > BMU_MAX_W) w = BMU_MAX_W;
        mask = (w >= DATA_W) ? ALL_ONES : ((64'd1 << w) - 64'd1);
        x    = opnd & mask;
        nx   = ~x & mask;
        r    = 32'(rot) % w;
        res  = '0;
        case (fn)
            FN_ROTL:   res = (r == 0) ? x : (((x << r) | (x >> (w - r))) & mask);
            FN_ROTR:   res = (r == 0) ? x : (((x >> r) | (x << (w - r))) & mask);
            FN_CLZ:    res = DATA_W'(lead_zero_count(x, w));
            FN_CLO:    res = DATA_W'(lead_zero_count(nx, w));
            FN_CTZ:    res = DATA_W'(trail_zero_count(x, w));
            FN_CTO:    res = DATA_W'(trail_zero_count(nx, w));
            FN_POPCNT: res = DATA_W'($countones(x));
            FN_ISPOW2: res = ($countones(x) == 1) ? 64'd1 : 64'd0;
            FN_FLOOR2: begin
                nbits = w - lead_zero_count(x, w);
                res   = (nbits == 0) ? 64'd0 : (64'd1 << (nbits - 1));
            end
            FN_CEIL2: begin
                if (x <= 64'd1) begin
                    res = 64'd1;
                end else begin
                    // round up: one past the top bit of x-1, zero when it leaves the width
                    nbits = w - lead_zero_count(x - 64'd1, w);
                    res   = (nbits >= w) ? 64'd0 : (64'd1 << nbits);
                end
            end
            FN_BITW:   res = DATA_W'(w - lead_zero_count(x, w));
            default:   res = '0;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Input side: one beat, with bursts and gaps
    // ---------------------------------------------------------------
    task automatic send_item(
        input logic [FUNC_W-1:0] fn, input logic [WSEL_W-1:0] wsel,
        input logic [DATA_W-1:0] opnd, input logic [ROT_W-1:0] rot
    );
        int unsigned gap;
        t_bmu_beat   beat;
        if (!steady_send && burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_width_sel <= wsel;
        i_operand   <= opnd;
        i_rot_count <= rot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beat.fn     = fn;
        beat.wsel   = wsel;
        beat.opnd   = opnd;
        beat.rot    = rot;
        beat.result = bmu_expected(fn, wsel, opnd, rot);
        pending_results.push_back(beat);
    endtask

    // random operation, width and count; operand shaped to hit count and rounding corners
    task automatic send_random_item();
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] opnd;
        logic [DATA_W-1:0] raw;
        int unsigned       k;
        fn  = ($urandom_range(0, 31) == 0)
            ? FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI))
            : FUNC_W'($urandom_range(0, FN_LAST));
        raw = {$urandom, $urandom};
        k   = $urandom_range(0, DATA_W - 1);
        case (t_opnd_shape'($urandom_range(0, 8)))
            OPND_FULL:        opnd = raw;
            OPND_ONE_HOT:     opnd = 64'd1 << k;
            OPND_LOW_MASK:    opnd = (64'd1 << k) - 64'd1;
            OPND_POW2_PLUS1:  opnd = (64'd1 << k) + 64'd1;
            OPND_LEAD_ZEROS:  opnd = raw >> k;
            OPND_TRAIL_ZEROS: opnd = raw << k;
            OPND_LEAD_ONES:   opnd = ~(raw >> k);
            OPND_EDGE:        opnd = raw[0] ? ALL_ONES : '0;
            default:          opnd = DATA_W'($urandom_range(0, 3));
        endcase
        send_item(fn, WSEL_W'($urandom_range(0, 3)), opnd,
                  ROT_W'($urandom_range(0, (1 << ROT_W) - 1)));
    endtask

    // drop valid and wait for every expected result, then for the pipe to settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Output side: stall pattern plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_sink
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned held;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_HALF:   i_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_bmu_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: result %h", o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result) begin
                    $error({"result: expected %h, actual %h ",
                            "(func %0d width_sel %0d operand %h rot_count %0d)"},
                           want.result, o_result, want.fn, want.wsel, want.opnd, want.rot);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        // rotates: zero count, count wrapping at the width, upper bits ignored
        send_item(FN_ROTL, WSEL_64, 64'h8000_0000_0000_0001, 6'd0);
        send_item(FN_ROTL, WSEL_8,  64'hFFFF_FFFF_FFFF_FF81, 6'd63);
        send_item(FN_ROTR, WSEL_16, 64'h0000_0000_0000_0001, 6'd16);
        send_item(FN_ROTR, WSEL_32, 64'hABCD_0000_1234_5678, 6'd63);
        send_item(FN_ROTL, WSEL_64, 64'hF0E1_D2C3_B4A5_9687, 6'd1);
        send_item(FN_ROTR, WSEL_64, 64'hF0E1_D2C3_B4A5_9687, 6'd63);
        // counts on all-zero and all-one operands give the width; also top-bit and power-of-two cases
        send_item(FN_CLZ,  WSEL_64, 64'd0, 6'd0);
        send_item(FN_CLZ,  WSEL_8,  64'hFF00, 6'd0);
        send_item(FN_CLO,  WSEL_16, 64'hFFFF, 6'd0);
        send_item(FN_CLO,  WSEL_64, ALL_ONES, 6'd0);
        send_item(FN_CTZ,  WSEL_32, 64'd0, 6'd0);
        send_item(FN_CTO,  WSEL_8,  64'hFF, 6'd0);
        send_item(FN_CTZ,  WSEL_64, TOP_BIT, 6'd0);
        send_item(FN_POPCNT, WSEL_64, ALL_ONES, 6'd0);
        send_item(FN_ISPOW2, WSEL_64, TOP_BIT, 6'd0);
        send_item(FN_ISPOW2, WSEL_8,  64'd0, 6'd0);
        // floor and ceiling: zero, one, top of range, overflow
        send_item(FN_FLOOR2, WSEL_32, 64'd0, 6'd0);
        send_item(FN_FLOOR2, WSEL_64, ALL_ONES, 6'd0);
        send_item(FN_CEIL2, WSEL_16, 64'd0, 6'd0);
        send_item(FN_CEIL2, WSEL_16, 64'd1, 6'd0);
        send_item(FN_CEIL2, WSEL_8,  64'h81, 6'd0);
        send_item(FN_CEIL2, WSEL_64, TOP_BIT, 6'd0);
        send_item(FN_CEIL2, WSEL_64, TOP_BIT + 64'd1, 6'd0);
        // bit width of zero and of all ones; unused codes
        send_item(FN_BITW, WSEL_64, 64'd0, 6'd0);
        send_item(FN_BITW, WSEL_64, ALL_ONES, 6'd0);
        send_item(FN_UNUSED_LO, WSEL_32, ALL_ONES, 6'd5);
        send_item(FN_UNUSED_HI, WSEL_64, ALL_ONES, 6'd63);
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering beats back to back
    task automatic test_output_holdoff();
        int k;
        hold_off_pending = 1'b1;
        steady_send      = 1'b1;
        for (k = 0; k < 40; k++) send_random_item();
        steady_send = 1'b0;
        drain_results();
    endtask

    task automatic test_random_items(input int count);
        int k;
        for (k = 0; k < count; k++) send_random_item();
        drain_results();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_output_holdoff();
        test_random_items(RANDOM_ITEMS);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bmu_pkg.sv
hdl/bit_manipulation_unit_top.sv
hdl/bmu_checker.sv
tb/testbench.sv
